FILE: rtl/ud_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
package ud_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [7:0] LeadMin = 8'hC2;
  localparam logic [7:0] LeadMax = 8'hF4;
  localparam logic [7:0] Lead3Min = 8'hE0;
  localparam logic [7:0] Lead4Min = 8'hF0;
  localparam logic [7:0] LeadE0 = 8'hE0;
  localparam logic [7:0] LeadF0 = 8'hF0;
  localparam logic [7:0] LeadF4 = 8'hF4;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_CHAR    = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_EMPTY   = 2'd2
  } status_e;

  // Allowed range for the next continuation byte.
  typedef enum logic [1:0] {
    RNG_80_BF = 2'd0,
    RNG_A0_BF = 2'd1,
    RNG_90_BF = 2'd2,
    RNG_80_8F = 2'd3
  } range_e;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic        flush;
    logic        ascii;
    logic        lead_ok;
    logic [1:0]  lead_left;
    range_e      lead_range;
    logic [4:0]  lead_bits;
    logic [3:0]  cont_ok;
    logic [7:0]  data;
  } ud_item_t;

endpackage

FILE: rtl/ud_in_if.sv
// Input channel: one UTF-8 byte or a flush request per item.
interface ud_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] in_byte;

  modport source (output valid, output mode, output in_byte, input ready);
  modport sink (input valid, input mode, input in_byte, output ready);
endinterface

FILE: rtl/ud_out_if.sv
// Output channel: one decode result per item.
interface ud_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [20:0] code_point;
  logic [2:0]  seq_len;

  modport source (output valid, output status, output code_point, output seq_len,
                  input ready);
  modport sink (input valid, input status, input code_point, input seq_len,
                output ready);
endinterface

FILE: rtl/ud_front.sv
// Front end: accepts bytes and classifies them for the decoder back end.
module ud_front import ud_pkg::*; (
  ud_in_if.sink    in_i,
  output ud_item_t item_o,
  output logic     item_valid_o,
  input  logic     item_ready_i
);

  logic [7:0] b;

  assign b            = in_i.in_byte;
  assign item_valid_o = in_i.valid;
  assign in_i.ready   = item_ready_i;

  always_comb begin
    item_o            = '0;
    item_o.flush      = in_i.mode;
    item_o.data       = b;
    item_o.ascii      = ~b[7];
    item_o.lead_ok    = (b >= LeadMin) && (b <= LeadMax);
    item_o.lead_range = RNG_80_BF;
    // Continuation checks for every range; the back end picks one by its state.
    item_o.cont_ok[RNG_80_BF] = (b[7:6] == 2'b10);
    item_o.cont_ok[RNG_A0_BF] = (b[7:5] == 3'b101);
    item_o.cont_ok[RNG_90_BF] = (b[7:6] == 2'b10) && (b[5:4] != 2'b00);
    item_o.cont_ok[RNG_80_8F] = (b[7:4] == 4'h8);
    if (b < Lead3Min) begin
      item_o.lead_left = 2'd1;
      item_o.lead_bits = b[4:0];
    end else if (b < Lead4Min) begin
      item_o.lead_left = 2'd2;
      item_o.lead_bits = {1'b0, b[3:0]};
      if (b == LeadE0) begin
        item_o.lead_range = RNG_A0_BF;
      end
    end else begin
      item_o.lead_left = 2'd3;
      item_o.lead_bits = {2'b00, b[2:0]};
      if (b == LeadF0) begin
        item_o.lead_range = RNG_90_BF;
      end else if (b == LeadF4) begin
        item_o.lead_range = RNG_80_8F;
      end
    end
  end

endmodule

FILE: rtl/ud_queue.sv
// Small queue of classified items between the front and back ends.
module ud_queue import ud_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ud_item_t push_item_i,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  output ud_item_t pop_item_o,
  output logic     pop_valid_o,
  input  logic     pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);
  localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  ud_item_t        slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = slots_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrOne;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrOne;
    end
    if (push && !pop) begin
      count_d = count_q + CntOne;
    end else if (pop && !push) begin
      count_d = count_q - CntOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count beyond depth");

endmodule

FILE: rtl/ud_back.sv
// Back end: sequence state, code point assembly and the output register.
module ud_back import ud_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ud_item_t item_i,
  input  logic     item_valid_i,
  output logic     item_ready_o,
  ud_out_if.source out_o
);

  logic [14:0] partial_q, partial_d;
  logic [1:0]  left_q, left_d;
  range_e      range_q, range_d;
  logic [2:0]  total_q, total_d;

  logic        out_valid_q;
  status_e     status_q, res_status;
  logic [20:0] cp_q, res_cp;
  logic [2:0]  len_q, res_len;
  logic        res_valid, pop;

  assign item_ready_o = !out_valid_q || out_o.ready;
  assign pop          = item_valid_i && item_ready_o;

  always_comb begin
    partial_d  = partial_q;
    left_d     = left_q;
    range_d    = range_q;
    total_d    = total_q;
    res_valid  = 1'b0;
    res_status = ST_CHAR;
    res_cp     = '0;
    res_len    = '0;
    if (item_i.flush) begin
      res_valid  = 1'b1;
      res_status = (left_q != 2'd0) ? ST_ILLEGAL : ST_EMPTY;
      partial_d  = '0;
      left_d     = '0;
      range_d    = RNG_80_BF;
      total_d    = '0;
    end else if (left_q == 2'd0) begin
      if (item_i.ascii) begin
        res_valid = 1'b1;
        res_cp    = {14'd0, item_i.data[6:0]};
        res_len   = 3'd1;
      end else if (item_i.lead_ok) begin
        partial_d = {10'd0, item_i.lead_bits};
        left_d    = item_i.lead_left;
        range_d   = item_i.lead_range;
        total_d   = {1'b0, item_i.lead_left} + 3'd1;
      end else begin
        res_valid  = 1'b1;
        res_status = ST_ILLEGAL;
      end
    end else if (!item_i.cont_ok[range_q]) begin
      res_valid  = 1'b1;
      res_status = ST_ILLEGAL;
      partial_d  = '0;
      left_d     = '0;
      range_d    = RNG_80_BF;
      total_d    = '0;
    end else if (left_q == 2'd1) begin
      // Last continuation byte completes the code point.
      res_valid = 1'b1;
      res_cp    = {partial_q, item_i.data[5:0]};
      res_len   = total_q;
      partial_d = '0;
      left_d    = '0;
      range_d   = RNG_80_BF;
      total_d   = '0;
    end else begin
      partial_d = {partial_q[8:0], item_i.data[5:0]};
      left_d    = left_q - 2'd1;
      range_d   = RNG_80_BF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q   <= '0;
      left_q      <= '0;
      range_q     <= RNG_80_BF;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        partial_q <= partial_d;
        left_q    <= left_d;
        range_q   <= range_d;
        total_q   <= total_d;
      end
      if (pop && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && res_valid) begin
      status_q <= res_status;
      cp_q     <= res_cp;
      len_q    <= res_len;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = status_q;
  assign out_o.code_point = cp_q;
  assign out_o.seq_len    = len_q;

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_q == 2'd0) |-> (total_q == 3'd0 && partial_q == '0 && range_q == RNG_80_BF))
    else $error("state not cleared with no sequence open");

  a_total_covers_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_q != 2'd0) |-> (total_q > {1'b0, left_q}))
    else $error("sequence length below bytes still due");

  a_range_only_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (range_q != RNG_80_BF) |-> (total_q == {1'b0, left_q} + 3'd1))
    else $error("special range outside the second byte");

  a_two_byte_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_CHAR && len_q == 3'd2) |-> (cp_q >= 21'h80))
    else $error("overlong two-byte sequence decoded");

  a_four_byte_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_CHAR && len_q == 3'd4) |->
      (cp_q >= 21'h10000 && cp_q <= 21'h10FFFF))
    else $error("four-byte code point out of range");

endmodule

FILE: rtl/utf8_stream_decoder.sv
// One item per cycle while the output is not stalled; the front end keeps taking
// bytes while a result waits, until the queue is full.
// A byte that only advances a sequence (lead or middle continuation) gives no result.
// Reset is asynchronous, active low, and empties the queue, the sequence state
// and the output register at once; the block is ready as soon as it is released.
module utf8_stream_decoder import ud_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ud_in_if.sink    in_i,
  ud_out_if.source out_o
);

  // The front end classifies each byte in the cycle it arrives: ASCII, valid
  // lead byte with its sequence length and the range its second byte must
  // meet, and the continuation checks for every range. The classified item is
  // then pushed into a small queue so the front keeps taking bytes while the
  // back end is held by a stalled output, until the queue is full.
  ud_item_t front_item, back_item;
  logic     front_valid, front_ready;
  logic     back_valid, back_ready;

  ud_front u_front (
    .in_i         (in_i),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready)
  );

  ud_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_item_i  (front_item),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_item_o   (back_item),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  // The back end holds the open sequence: the gathered code point bits, the
  // continuation bytes still due, the range for the next one and the total
  // length. A bad byte or a flush clears this state. Results land in an output
  // register that the back end refills in the same cycle it is drained.
  ud_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (back_item),
    .item_valid_i (back_valid),
    .item_ready_o (back_ready),
    .out_o        (out_o)
  );

endmodule
